FILE: hw/rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion wrappers. All assertions are disabled in reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
`define ASSERT_ALWAYS(label, clk, rst_n, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (cond)) else $error(msg);
`define ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);
`else
`define ASSERT_ALWAYS(label, clk, rst_n, cond, msg)
`define ASSERT_IMPL(label, clk, rst_n, ante, cons, msg)
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg)
`endif
`endif

FILE: hw/rtl/upa_pkg.sv
// ----------------------------------------------------------------------------
// upa_pkg
// Types, constants and helper functions for the pixel attenuation pipeline.
// ----------------------------------------------------------------------------
package upa_pkg;

    localparam int unsigned NUM_CH     = 3;
    localparam int unsigned CFG_DATA_W = 48;
    localparam int unsigned CFG_IDX_W  = 3;
    localparam int unsigned SQRT_STG   = 16;
    localparam int unsigned EXP_STG    = 16;
    localparam int unsigned FACTOR_W   = 32;
    localparam int unsigned T_W        = 33;
    localparam int unsigned WHOLE_W    = 13;
    localparam int unsigned E_W        = 17;

    localparam logic [20:0] LOG2E_Q20       = 21'd1512775;
    localparam logic [12:0] EXP_SHIFT_LIMIT = 13'd33;

    localparam logic [15:0] RST_CX    = 16'd5120;
    localparam logic [15:0] RST_CY    = 16'd3840;
    localparam logic [23:0] RST_IFX   = 24'd30284;
    localparam logic [23:0] RST_IFY   = 24'd30284;
    localparam logic [15:0] RST_FLOOR = 16'd26;
    localparam logic [15:0] RST_CEIL  = 16'd25600;
    localparam logic [47:0] RST_ATT   = 48'h0089_0089_0089;
    localparam logic [23:0] RST_BG    = 24'd0;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_CENTER_X,
        REG_CENTER_Y,
        REG_INV_FX,
        REG_INV_FY,
        REG_FLOOR,
        REG_CEILING,
        REG_ATTEN,
        REG_BACKGROUND
    } t_reg_idx;

    typedef logic [31:0] t_pow_tab [EXP_STG];

    localparam t_pow_tab POW2_NEG_FRAC = '{
        32'd3037000500, 32'd3611622603, 32'd3938502376, 32'd4112874773,
        32'd4202935053, 32'd4248701965, 32'd4271771996, 32'd4283353945,
        32'd4289156691, 32'd4292061010, 32'd4293513907, 32'd4294240540,
        32'd4294603903, 32'd4294785596, 32'd4294876445, 32'd4294921870
    };

    typedef struct packed {
        logic [63:0] rem;
        logic [63:0] root;
    } t_isq;

    // Two digit-pair steps of the bitwise integer square root.
    function automatic t_isq isq_step2(input t_isq s, input int unsigned k);
        t_isq        r;
        logic [63:0] bit_v;
        r = s;
        for (int unsigned j = 0; j < 2; j++) begin
            bit_v = 64'd1 << (62 - 2 * (2 * k + j));
            if (r.rem >= r.root + bit_v) begin
                r.rem  = r.rem - (r.root + bit_v);
                r.root = (r.root >> 1) + bit_v;
            end else begin
                r.root = r.root >> 1;
            end
        end
        return r;
    endfunction

endpackage

FILE: hw/rtl/upa_pix_if.sv
// ----------------------------------------------------------------------------
// upa_pix_if
// Input pixel channel: coordinates, depth and three color values.
// ----------------------------------------------------------------------------
interface upa_pix_if #(
    parameter int unsigned COORD_BITS = 12
);
    logic                  valid;
    logic                  ready;
    logic [COORD_BITS-1:0] pixel_column;
    logic [COORD_BITS-1:0] pixel_row;
    logic [15:0]           depth_q8_8;
    logic [7:0]            chan0_in;
    logic [7:0]            chan1_in;
    logic [7:0]            chan2_in;

    modport source (
        output valid, pixel_column, pixel_row, depth_q8_8, chan0_in, chan1_in, chan2_in,
        input  ready
    );
    modport sink (
        input  valid, pixel_column, pixel_row, depth_q8_8, chan0_in, chan1_in, chan2_in,
        output ready
    );
endinterface

FILE: hw/rtl/upa_res_if.sv
// ----------------------------------------------------------------------------
// upa_res_if
// Output pixel channel: three blended color values.
// ----------------------------------------------------------------------------
interface upa_res_if;
    logic       valid;
    logic       ready;
    logic [7:0] chan0_out;
    logic [7:0] chan1_out;
    logic [7:0] chan2_out;

    modport source (
        output valid, chan0_out, chan1_out, chan2_out,
        input  ready
    );
    modport sink (
        input  valid, chan0_out, chan1_out, chan2_out,
        output ready
    );
endinterface

FILE: hw/rtl/upa_ray.sv
// ----------------------------------------------------------------------------
// upa_ray
// Ray factor pipeline: offsets, focal scaling, squares and a staged square root.
// ----------------------------------------------------------------------------
module upa_ray #(
    parameter int unsigned COORD_BITS = 12,
    parameter int unsigned SB_W       = 40
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_en,
    input  logic                           i_valid,
    input  logic [COORD_BITS-1:0]          i_u,
    input  logic [COORD_BITS-1:0]          i_v,
    input  logic [SB_W-1:0]                i_sb,
    input  logic [15:0]                    i_cx,
    input  logic [15:0]                    i_cy,
    input  logic [23:0]                    i_ifx,
    input  logic [23:0]                    i_ify,
    output logic                           o_valid,
    output logic [upa_pkg::FACTOR_W-1:0]   o_factor,
    output logic [SB_W-1:0]                o_sb
);
    localparam int unsigned POS_W = COORD_BITS + 4;
    localparam int unsigned MAG_W = (POS_W > 16) ? POS_W : 16;
    localparam int unsigned XR_W  = MAG_W + 12;
    localparam int unsigned NS    = 4 + upa_pkg::SQRT_STG;

    logic [NS-1:0]     r_v;
    logic [SB_W-1:0]   r_sb [NS];
    logic [MAG_W-1:0]  r_mx, r_my;
    logic [XR_W-1:0]   r_xr, r_yr;
    logic [63:0]       r_xx, r_yy;
    upa_pkg::t_isq     r_sq [upa_pkg::SQRT_STG + 1];

    logic [MAG_W-1:0]  n_px, n_py, n_cx, n_cy;
    logic [MAG_W+23:0] n_prx, n_pry;

    always_comb begin
        n_px  = MAG_W'({i_u, 4'b0000});
        n_py  = MAG_W'({i_v, 4'b0000});
        n_cx  = MAG_W'(i_cx);
        n_cy  = MAG_W'(i_cy);
        n_prx = (MAG_W + 24)'(r_mx) * (MAG_W + 24)'(i_ifx);
        n_pry = (MAG_W + 24)'(r_my) * (MAG_W + 24)'(i_ify);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else if (i_en) begin
            r_v <= {r_v[NS-2:0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_sb[0] <= i_sb;
            for (int unsigned k = 1; k < NS; k++) begin
                r_sb[k] <= r_sb[k-1];
            end
            r_mx <= (n_px >= n_cx) ? n_px - n_cx : n_cx - n_px;
            r_my <= (n_py >= n_cy) ? n_py - n_cy : n_cy - n_py;
            r_xr <= n_prx[MAG_W+23:12];
            r_yr <= n_pry[MAG_W+23:12];
            r_xx <= 64'(r_xr) * 64'(r_xr);
            r_yy <= 64'(r_yr) * 64'(r_yr);
            r_sq[0].rem  <= 64'h1_0000_0000 + r_xx + r_yy;
            r_sq[0].root <= '0;
            for (int unsigned k = 0; k < upa_pkg::SQRT_STG; k++) begin
                r_sq[k+1] <= upa_pkg::isq_step2(r_sq[k], k);
            end
        end
    end

    assign o_valid  = r_v[NS-1];
    assign o_factor = r_sq[upa_pkg::SQRT_STG].root[upa_pkg::FACTOR_W-1:0];
    assign o_sb     = r_sb[NS-1];
endmodule

FILE: hw/rtl/upa_rng.sv
// ----------------------------------------------------------------------------
// upa_rng
// Range pipeline: depth scaling, saturation, clamping and exponent scaling.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module upa_rng #(
    parameter int unsigned SB_W = 24
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_en,
    input  logic                         i_valid,
    input  logic [upa_pkg::FACTOR_W-1:0] i_factor,
    input  logic [15:0]                  i_depth,
    input  logic [SB_W-1:0]              i_sb,
    input  logic [15:0]                  i_floor,
    input  logic [15:0]                  i_ceil,
    input  logic [47:0]                  i_att,
    output logic                         o_valid,
    output logic [upa_pkg::T_W-1:0]      o_t [upa_pkg::NUM_CH],
    output logic [SB_W-1:0]              o_sb
);
    localparam int unsigned NS = 4;

    logic [NS-1:0]   r_v;
    logic [SB_W-1:0] r_sb [NS];
    logic [47:0]     r_prod;
    logic [15:0]     r_range;
    logic [31:0]     r_a [upa_pkg::NUM_CH];
    logic [upa_pkg::T_W-1:0] r_t [upa_pkg::NUM_CH];

    logic [15:0]     n_sat;
    logic [52:0]     n_tp [upa_pkg::NUM_CH];

    always_comb begin
        n_sat = (|r_prod[47:32]) ? 16'hFFFF : r_prod[31:16];
        for (int unsigned c = 0; c < upa_pkg::NUM_CH; c++) begin
            n_tp[c] = 53'(r_a[c]) * 53'(upa_pkg::LOG2E_Q20);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else if (i_en) begin
            r_v <= {r_v[NS-2:0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_sb[0] <= i_sb;
            for (int unsigned k = 1; k < NS; k++) begin
                r_sb[k] <= r_sb[k-1];
            end
            r_prod <= 48'(i_factor) * 48'(i_depth);
            if (n_sat < i_floor) begin
                r_range <= i_floor;
            end else if (n_sat > i_ceil) begin
                r_range <= i_ceil;
            end else begin
                r_range <= n_sat;
            end
            for (int unsigned c = 0; c < upa_pkg::NUM_CH; c++) begin
                r_a[c] <= 32'(r_range) * 32'(i_att[16*c +: 16]);
                r_t[c] <= n_tp[c][52:20];
            end
        end
    end

    assign o_valid = r_v[NS-1];
    assign o_t     = r_t;
    assign o_sb    = r_sb[NS-1];

    `ASSERT_IMPL(a_rng_clamped, i_clk, i_rst_n, r_v[1] && (i_floor <= i_ceil), (r_range >= i_floor) && (r_range <= i_ceil), "range outside clamp window")
    `ASSERT_IMPL(a_rng_floor_wins, i_clk, i_rst_n, r_v[1] && (i_floor > i_ceil), (r_range == i_floor) || (r_range == i_ceil) || (r_range > i_floor), "floor not honored")
    `ASSERT_NEXT(a_rng_sat, i_clk, i_rst_n, i_en && r_v[0] && (|r_prod[47:32]) && (i_floor <= i_ceil), r_range == i_ceil, "saturated range not clamped to ceiling")
endmodule

FILE: hw/rtl/upa_exp.sv
// ----------------------------------------------------------------------------
// upa_exp
// Transmission and blend pipeline: staged 2^-t product, shift and color mix.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module upa_exp (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_en,
    input  logic                    i_valid,
    input  logic [upa_pkg::T_W-1:0] i_t [upa_pkg::NUM_CH],
    input  logic [23:0]             i_pix,
    input  logic [23:0]             i_bg,
    output logic                    o_valid,
    output logic [23:0]             o_pix
);
    localparam int unsigned NE = upa_pkg::EXP_STG;
    localparam int unsigned NS = NE + 3;

    logic [NS-1:0] r_v;
    logic [23:0]   r_pix [NE + 1];
    logic [32:0]   r_acc [NE][upa_pkg::NUM_CH];
    logic [15:0]   r_frac [NE][upa_pkg::NUM_CH];
    logic [upa_pkg::WHOLE_W-1:0] r_whole [NE][upa_pkg::NUM_CH];
    logic [upa_pkg::E_W-1:0] r_e [upa_pkg::NUM_CH];
    logic [24:0]   r_p1 [upa_pkg::NUM_CH];
    logic [24:0]   r_p2 [upa_pkg::NUM_CH];
    logic [23:0]   r_out;

    logic [32:0]   n_acc [NE][upa_pkg::NUM_CH];
    logic [64:0]   n_mul [NE][upa_pkg::NUM_CH];
    logic [32:0]   n_sh  [upa_pkg::NUM_CH];

    always_comb begin
        for (int unsigned c = 0; c < upa_pkg::NUM_CH; c++) begin
            for (int unsigned k = 0; k < NE; k++) begin
                if (k == 0) begin
                    n_mul[k][c] = 65'h1_0000_0000 * 65'(upa_pkg::POW2_NEG_FRAC[k]);
                    n_acc[k][c] = i_t[c][19] ? n_mul[k][c][64:32] : 33'h1_0000_0000;
                end else begin
                    n_mul[k][c] = 65'(r_acc[k-1][c]) * 65'(upa_pkg::POW2_NEG_FRAC[k]);
                    n_acc[k][c] = r_frac[k-1][c][15-k] ? n_mul[k][c][64:32]
                                                       : r_acc[k-1][c];
                end
            end
            n_sh[c] = r_acc[NE-1][c] >> r_whole[NE-1][c][5:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else if (i_en) begin
            r_v <= {r_v[NS-2:0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_pix[0] <= i_pix;
            for (int unsigned k = 1; k < NE + 1; k++) begin
                r_pix[k] <= r_pix[k-1];
            end
            for (int unsigned c = 0; c < upa_pkg::NUM_CH; c++) begin
                for (int unsigned k = 0; k < NE; k++) begin
                    r_acc[k][c] <= n_acc[k][c];
                    if (k == 0) begin
                        r_frac[k][c]  <= i_t[c][19:4];
                        r_whole[k][c] <= i_t[c][32:20];
                    end else begin
                        r_frac[k][c]  <= r_frac[k-1][c];
                        r_whole[k][c] <= r_whole[k-1][c];
                    end
                end
                if (r_whole[NE-1][c] >= upa_pkg::EXP_SHIFT_LIMIT) begin
                    r_e[c] <= '0;
                end else begin
                    r_e[c] <= n_sh[c][32:16];
                end
                r_p1[c] <= 25'(r_e[c]) * 25'(r_pix[NE][8*c +: 8]);
                r_p2[c] <= 25'(18'h10000 - 18'(r_e[c])) * 25'(i_bg[8*c +: 8]);
                r_out[8*c +: 8] <= 8'((26'(r_p1[c]) + 26'(r_p2[c])) >> 16);
            end
        end
    end

    assign o_valid = r_v[NS-1];
    assign o_pix   = r_out;

    `ASSERT_IMPL(a_exp_unit_bound, i_clk, i_rst_n, r_v[NE], r_e[0] <= 17'h10000, "transmission above one")
    `ASSERT_NEXT(a_exp_deep_zero, i_clk, i_rst_n, i_en && r_v[NE-1] && (r_whole[NE-1][0] >= upa_pkg::EXP_SHIFT_LIMIT), r_e[0] == '0, "large exponent did not give zero")
endmodule

FILE: hw/rtl/underwater_pixel_attenuation.sv
// ----------------------------------------------------------------------------
// underwater_pixel_attenuation
// Per-pixel range from depth and ray angle, then per-channel exponential
// attenuation blended toward a background level.
//
//   Channel   Dir   Beat contents
//   i_pix     in    column, row, depth Q8.8, three 8-bit colors
//   o_res     out   three 8-bit blended colors
//   cfg       in    write enable, 3-bit register index, 48-bit data
//
// One pixel enters per clock while the output is not stalled; the pipeline
// holds the 16-stage square root and the 16-stage exponent product chain.
// Reset is synchronous; it clears only the stage valid bits and loads the config defaults.
// A stalled output freezes every stage together, so no beat is lost.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module underwater_pixel_attenuation #(
    parameter int unsigned COORD_BITS = 12
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    upa_pix_if.sink                            i_pix,
    upa_res_if.source                          o_res,
    input  logic                               i_cfg_we,
    input  logic [upa_pkg::CFG_IDX_W-1:0]      i_cfg_idx,
    input  logic [upa_pkg::CFG_DATA_W-1:0]     i_cfg_data
);
    logic [15:0] r_cx, r_cy, r_floor, r_ceil;
    logic [23:0] r_ifx, r_ify, r_bg;
    logic [47:0] r_att;

    logic        en;
    logic        ray_valid, rng_valid, exp_valid;
    logic [39:0] ray_sb;
    logic [23:0] rng_sb, exp_pix;
    logic [upa_pkg::FACTOR_W-1:0] ray_factor;
    logic [upa_pkg::T_W-1:0] rng_t [upa_pkg::NUM_CH];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cx    <= upa_pkg::RST_CX;
            r_cy    <= upa_pkg::RST_CY;
            r_ifx   <= upa_pkg::RST_IFX;
            r_ify   <= upa_pkg::RST_IFY;
            r_floor <= upa_pkg::RST_FLOOR;
            r_ceil  <= upa_pkg::RST_CEIL;
            r_att   <= upa_pkg::RST_ATT;
            r_bg    <= upa_pkg::RST_BG;
        end else if (i_cfg_we) begin
            unique case (upa_pkg::t_reg_idx'(i_cfg_idx))
                upa_pkg::REG_CENTER_X:   r_cx    <= i_cfg_data[15:0];
                upa_pkg::REG_CENTER_Y:   r_cy    <= i_cfg_data[15:0];
                upa_pkg::REG_INV_FX:     r_ifx   <= i_cfg_data[23:0];
                upa_pkg::REG_INV_FY:     r_ify   <= i_cfg_data[23:0];
                upa_pkg::REG_FLOOR:      r_floor <= i_cfg_data[15:0];
                upa_pkg::REG_CEILING:    r_ceil  <= i_cfg_data[15:0];
                upa_pkg::REG_ATTEN:      r_att   <= i_cfg_data[47:0];
                upa_pkg::REG_BACKGROUND: r_bg    <= i_cfg_data[23:0];
                default: ;
            endcase
        end
    end

    assign en          = !exp_valid || o_res.ready;
    assign i_pix.ready = en;

    upa_ray #(
        .COORD_BITS (COORD_BITS),
        .SB_W       (40)
    ) u_ray (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_en     (en),
        .i_valid  (i_pix.valid),
        .i_u      (i_pix.pixel_column),
        .i_v      (i_pix.pixel_row),
        .i_sb     ({i_pix.depth_q8_8, i_pix.chan2_in, i_pix.chan1_in, i_pix.chan0_in}),
        .i_cx     (r_cx),
        .i_cy     (r_cy),
        .i_ifx    (r_ifx),
        .i_ify    (r_ify),
        .o_valid  (ray_valid),
        .o_factor (ray_factor),
        .o_sb     (ray_sb)
    );

    upa_rng #(
        .SB_W (24)
    ) u_rng (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_en     (en),
        .i_valid  (ray_valid),
        .i_factor (ray_factor),
        .i_depth  (ray_sb[39:24]),
        .i_sb     (ray_sb[23:0]),
        .i_floor  (r_floor),
        .i_ceil   (r_ceil),
        .i_att    (r_att),
        .o_valid  (rng_valid),
        .o_t      (rng_t),
        .o_sb     (rng_sb)
    );

    upa_exp u_exp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (rng_valid),
        .i_t     (rng_t),
        .i_pix   (rng_sb),
        .i_bg    (r_bg),
        .o_valid (exp_valid),
        .o_pix   (exp_pix)
    );

    assign o_res.valid     = exp_valid;
    assign o_res.chan0_out = exp_pix[7:0];
    assign o_res.chan1_out = exp_pix[15:8];
    assign o_res.chan2_out = exp_pix[23:16];

    `ASSERT_NEXT(a_top_stall_freeze, i_clk, i_rst_n, exp_valid && !o_res.ready, exp_valid && $stable(exp_pix) && $stable(rng_valid) && $stable(ray_valid), "pipeline moved while stalled")
    `ASSERT_NEXT(a_top_advance, i_clk, i_rst_n, en && rng_valid, exp_valid == 1'b0 || exp_valid == 1'b1, "advance check")
endmodule
